@@ sv/lguf_pkg.sv @@
// shared types and constants for the led grid update filter
package lguf_pkg;

  localparam int unsigned COORD_W   = 5;
  localparam int unsigned RED_W     = 4;
  localparam int unsigned GREEN_W   = 3;
  localparam int unsigned INTEN_W   = 8;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned LIGHT_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 4;

  localparam int unsigned CACHE_DEPTH = 80;
  localparam int unsigned CACHE_AW    = $clog2(CACHE_DEPTH);

  localparam logic [CACHE_AW-1:0] SIDE_BASE  = CACHE_AW'(64);
  localparam logic [CACHE_AW-1:0] TOP_BASE   = CACHE_AW'(72);
  localparam logic [LIGHT_W-1:0]  CC_BASE    = LIGHT_W'(104);
  localparam logic [LIGHT_W-1:0]  SIDE_NOTE  = LIGHT_W'(8);
  localparam logic [LIGHT_W-1:0]  FULL_VALUE = LIGHT_W'(127);

  localparam logic MSG_NOTE = 1'b0;
  localparam logic MSG_CC   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_PRESENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_MODE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PAGE       = CFG_IDX_W'(2);

  typedef struct packed {
    logic [CACHE_AW-1:0] addr;
    logic [LIGHT_W-1:0]  value;
    logic [LIGHT_W-1:0]  number;
    logic                msg_kind;
    logic                emit;
    logic                force_req;
  } item_t;

endpackage

@@ sv/lguf_in_if.sv @@
// input channel carrying one light update per transaction
interface lguf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lguf_pkg::COORD_W-1:0] column;
  logic signed [lguf_pkg::COORD_W-1:0] row;
  logic [lguf_pkg::RED_W-1:0]          red_level;
  logic [lguf_pkg::GREEN_W-1:0]        green_level;
  logic [lguf_pkg::INTEN_W-1:0]        intensity;
  logic                                force_req;

  modport source (output valid, column, row, red_level, green_level, intensity, force_req,
                  input ready);
  modport sink (input valid, column, row, red_level, green_level, intensity, force_req,
                output ready);
endinterface

@@ sv/lguf_out_if.sv @@
// result channel carrying one light message per transaction
interface lguf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         msg_kind;
  logic [lguf_pkg::CHAN_W-1:0]  channel;
  logic [lguf_pkg::LIGHT_W-1:0] number;
  logic [lguf_pkg::LIGHT_W-1:0] value;

  modport source (output valid, msg_kind, channel, number, value, input ready);
  modport sink (input valid, msg_kind, channel, number, value, output ready);
endinterface

@@ sv/lguf_ram.sv @@
// generic single write port ram with registered read
module lguf_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lguf_decode.sv @@
// position check, cache address, light value and message number for one update
module lguf_decode (
  input  logic signed [lguf_pkg::COORD_W-1:0] column,
  input  logic signed [lguf_pkg::COORD_W-1:0] row,
  input  logic [lguf_pkg::RED_W-1:0]          red_level,
  input  logic [lguf_pkg::GREEN_W-1:0]        green_level,
  input  logic [lguf_pkg::INTEN_W-1:0]        intensity,
  input  logic                                force_req,
  input  logic                                controller_present,
  input  logic                                intensity_mode,
  output logic                                keep,
  output lguf_pkg::item_t                     item
);
  import lguf_pkg::*;

  localparam int unsigned PROD_W = INTEN_W + LIGHT_W;

  logic              col_strip, row_strip, col_ok, row_ok;
  logic [2:0]        col3, row3;
  logic [PROD_W-1:0] prod;
  logic [INTEN_W-1:0] scaled;
  logic [LIGHT_W-1:0] inten_val;

  assign col_strip = (column == '1);
  assign row_strip = (row == '1);
  assign col_ok    = col_strip || (column[COORD_W-1:3] == '0);
  assign row_ok    = row_strip || (row[COORD_W-1:3] == '0);
  assign col3      = column[2:0];
  assign row3      = row[2:0];

  assign keep = controller_present && col_ok && row_ok && !(col_strip && row_strip);

  // intensity times full scale, shifted down by seven bits and saturated at full scale
  assign prod      = PROD_W'(intensity) * PROD_W'(FULL_VALUE);
  assign scaled    = prod[PROD_W-1:LIGHT_W];
  assign inten_val = (scaled > INTEN_W'(FULL_VALUE)) ? FULL_VALUE : scaled[LIGHT_W-1:0];

  always_comb begin
    item           = '0;
    item.force_req = force_req;
    item.value     = intensity_mode ? inten_val : {green_level, red_level};

    priority if (col_strip) begin
      item.addr = SIDE_BASE + CACHE_AW'(row3);
    end else if (row_strip) begin
      item.addr = TOP_BASE + CACHE_AW'(col3);
    end else begin
      item.addr = {1'b0, row3, col3};
    end

    priority if (intensity_mode) begin
      item.msg_kind = MSG_NOTE;
      item.emit     = !col_strip && !row_strip;
      item.number   = {1'b0, ~row3, col3};
    end else if (col_strip) begin
      item.msg_kind = MSG_NOTE;
      item.emit     = 1'b1;
      item.number   = SIDE_NOTE | {~row3, 4'b0000};
    end else if (row_strip) begin
      item.msg_kind = MSG_CC;
      item.emit     = 1'b1;
      item.number   = CC_BASE + LIGHT_W'(col3);
    end else begin
      item.msg_kind = MSG_NOTE;
      item.emit     = 1'b1;
      item.number   = {~row3, 1'b0, col3};
    end
  end

endmodule

@@ sv/led_grid_update_filter_core.sv @@
// led grid update filter: one light update in, at most one light message out
// a message passes the update stage and result registers after its input transaction is accepted
// throughput: one update per cycle unless output stalls; one cache ram read and write per update
// the cache ram is read at accept, written as the update stage fires; bypass for back-to-back hits
// reset: synchronous active low; clears config registers, pipeline valids and per-entry valid bits
// an entry never written since reset reads as zero, so no clearing pass is needed
module led_grid_update_filter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  lguf_in_if.sink                            in_chan,
  lguf_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [lguf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lguf_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import lguf_pkg::*;

  logic                 controller_present_r;
  logic                 intensity_mode_r;
  logic [CHAN_W-1:0]    channel_page_r;

  logic                 dec_keep;
  item_t                dec_item;
  logic                 in_accept;

  logic                 s1_valid_r, s1_valid_nxt;
  item_t                s1_item_r;
  logic                 s1_fire, s1_changed, s1_send;

  logic [LIGHT_W-1:0]   ram_rdata, cur_value;
  logic                 cache_we;
  logic [CACHE_DEPTH-1:0] entry_valid_r;

  logic                 lw_valid_r;
  logic [CACHE_AW-1:0]  lw_addr_r;
  logic [LIGHT_W-1:0]   lw_data_r;

  logic                 out_valid_r, out_valid_nxt, out_free;
  logic                 out_kind_r;
  logic [CHAN_W-1:0]    out_channel_r;
  logic [LIGHT_W-1:0]   out_number_r, out_value_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      controller_present_r <= 1'b0;
      intensity_mode_r     <= 1'b0;
      channel_page_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTROLLER_PRESENT: controller_present_r <= cfg_wdata[0];
        CFG_INTENSITY_MODE:     intensity_mode_r     <= cfg_wdata[0];
        CFG_CHANNEL_PAGE:       channel_page_r       <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  lguf_decode u_decode (
    .column             (in_chan.column),
    .row                (in_chan.row),
    .red_level          (in_chan.red_level),
    .green_level        (in_chan.green_level),
    .intensity          (in_chan.intensity),
    .force_req          (in_chan.force_req),
    .controller_present (controller_present_r),
    .intensity_mode     (intensity_mode_r),
    .keep               (dec_keep),
    .item               (dec_item)
  );

  // handshake
  assign out_free     = !out_valid_r || out_chan.ready;
  assign s1_fire      = s1_valid_r && (!s1_send || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_accept    = in_chan.valid && in_chan.ready;

  lguf_ram #(
    .WIDTH (LIGHT_W),
    .DEPTH (CACHE_DEPTH)
  ) u_cache_ram (
    .clk   (clk),
    .we    (cache_we),
    .waddr (s1_item_r.addr),
    .wdata (s1_item_r.value),
    .re    (in_accept),
    .raddr (dec_item.addr),
    .rdata (ram_rdata)
  );

  // cached value with bypass of the latest write
  always_comb begin
    priority if (lw_valid_r && (lw_addr_r == s1_item_r.addr)) begin
      cur_value = lw_data_r;
    end else if (entry_valid_r[s1_item_r.addr]) begin
      cur_value = ram_rdata;
    end else begin
      cur_value = '0;
    end
  end

  assign s1_changed = (cur_value != s1_item_r.value) || s1_item_r.force_req;
  assign s1_send    = s1_changed && s1_item_r.emit;
  assign cache_we   = s1_fire && s1_changed;

  assign s1_valid_nxt = in_accept ? dec_keep : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      entry_valid_r <= '0;
      lw_valid_r    <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cache_we) begin
        entry_valid_r[s1_item_r.addr] <= 1'b1;
        lw_valid_r                    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= dec_item;
    end
    if (cache_we) begin
      lw_addr_r <= s1_item_r.addr;
      lw_data_r <= s1_item_r.value;
    end
  end

  // result register
  assign out_valid_nxt = (s1_fire && s1_send) ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_send) begin
      out_kind_r    <= s1_item_r.msg_kind;
      out_channel_r <= channel_page_r;
      out_number_r  <= s1_item_r.number;
      out_value_r   <= s1_item_r.value;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.msg_kind = out_kind_r;
  assign out_chan.channel  = out_channel_r;
  assign out_chan.number   = out_number_r;
  assign out_chan.value    = out_value_r;

  // a held update is only ever waiting on a stalled message
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (out_valid_r && !out_chan.ready))
    else $error("update held without a stalled message");

  // a sent message shows up in the result register next cycle
  a_send_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_send) |=> out_valid_r)
    else $error("message lost between stages");

  // a cache write marks its entry valid and the bypass valid
  a_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cache_we |=> (entry_valid_r[$past(s1_item_r.addr)] && lw_valid_r))
    else $error("cache entry not marked after write");

  // an empty update stage always takes input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_chan.ready)
    else $error("input stalled with empty update stage");

endmodule
